// File: rtl/core/nqe_pkg.sv
// Shared types and constants for the n-queens solution enumerator.
package nqe_pkg;

  // Width of one column code and of the board size register
  localparam int COL_W     = 4;
  localparam int SIZE_W    = 4;
  // Rows reported in the placement word
  localparam int PLACE_ROWS = 8;
  localparam int PLACE_W   = PLACE_ROWS * COL_W;
  localparam int COUNT_W   = 24;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = PLACE_W + COUNT_W;
  // Attack masks held per row: column, down-left diagonal, down-right diagonal
  localparam int ATT_N     = 3;
  localparam int ATT_COL   = 0;
  localparam int ATT_DL    = 1;
  localparam int ATT_DR    = 2;
  // Board size after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  // Per-row cell controls
  typedef struct packed {
    logic place;  // latch the candidate column as this row's queen
    logic take;   // derive this row's attack masks from the row below
  } cell_ctl_t;

endpackage

// File: rtl/core/nqe_cell.sv
// One row cell: holds the row's queen column and the attack masks seen by the row.
module nqe_cell #(
  parameter int MAX_SIZE = 8
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  nqe_pkg::cell_ctl_t                           ctl,
  input  logic [nqe_pkg::COL_W-1:0]                    cand_col,
  input  logic [nqe_pkg::ATT_N-1:0][MAX_SIZE-1:0]      prev_att,
  output logic [nqe_pkg::COL_W-1:0]                    col,
  output logic [nqe_pkg::ATT_N-1:0][MAX_SIZE-1:0]      att
);
  import nqe_pkg::*;

  logic [MAX_SIZE-1:0]              cand_oh;
  logic [ATT_N-1:0][MAX_SIZE-1:0]   att_nxt;
  logic [ATT_N-1:0][MAX_SIZE-1:0]   att_r;
  logic [COL_W-1:0]                 col_r;

  // Add the queen placed on the row below and shift the diagonals one row on
  assign cand_oh = {{(MAX_SIZE-1){1'b0}}, 1'b1} << cand_col;
  always_comb begin
    att_nxt[ATT_COL] = prev_att[ATT_COL] | cand_oh;
    att_nxt[ATT_DL]  = (prev_att[ATT_DL] | cand_oh) << 1;
    att_nxt[ATT_DR]  = (prev_att[ATT_DR] | cand_oh) >> 1;
  end

  // Load masks when the row below places its queen
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      att_r <= '0;
    end else if (ctl.take) begin
      att_r <= att_nxt;
    end
  end

  // Hold this row's queen column
  always_ff @(posedge clk) begin
    if (ctl.place) begin
      col_r <= cand_col;
    end
  end

  assign col = col_r;
  assign att = att_r;

endmodule

// File: rtl/core/n_queens_solution_enumerator.sv
// Top level of the n-queens solution enumerator: search sequencer over a chain of row cells.
//
// Usage:
//   Input channel (in_*): one transaction per request. in_tdata[0] is restart:
//   1 clears the search and returns the first placement, 0 returns the next one.
//   Result channel (out_*): one transaction per request. out_tdata carries the
//   placement (bits 31:0, 4 bits per row, row 0 lowest) and the running solution
//   count (bits 55:32); out_tuser is the found flag, 0 once the search is spent.
//   Configuration: cfg_wr_en with cfg_wr_data writes the board size (0 acts as 1,
//   sizes above MAX_SIZE act as MAX_SIZE) and clears the search. Write only idle.
// Timing:
//   The sequencer makes one column trial or one backtrack step per cycle, with the
//   safety check done in parallel against the masks held in the current row's cell;
//   only its final step waits for a busy output register. The result is registered on
//   that final step, as the sequencer returns to idle and can take the next request.
//   A spent search answers on its first step, without any trials or backtracks.
//   One request is in flight at a time; in_tready is high while the sequencer idles.
// Reset and stall:
//   Reset sets the board size to 8 and empties the search. While a result waits
//   on a stalled receiver the next request is still taken and searched; the
//   sequencer holds on its final step until the output register is free.
module n_queens_solution_enumerator #(
  parameter int MAX_SIZE = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [nqe_pkg::IN_DATA_W-1:0]     in_tdata,   // [0] restart, [7:1] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [nqe_pkg::OUT_DATA_W-1:0]    out_tdata,  // [31:0] placement, [55:32] solution_number
  output logic                              out_tuser,  // [0] found
  input  logic                              cfg_wr_en,
  input  logic [nqe_pkg::SIZE_W-1:0]        cfg_wr_data
);
  import nqe_pkg::*;

  localparam int RW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int NW = $clog2(MAX_SIZE + 1);

  // Search state
  state_t               state_r, state_nxt;
  logic [SIZE_W-1:0]    bs_r;
  logic [RW-1:0]        r_r, r_nxt;
  logic [NW-1:0]        c_r, c_nxt;
  logic                 exh_r, exh_nxt;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt;

  // Result register
  logic                 out_valid_r;
  logic [PLACE_W-1:0]   out_place_r;
  logic [COUNT_W-1:0]   out_cnt_r;
  logic                 out_found_r;

  // Cell chain
  logic [ATT_N-1:0][MAX_SIZE-1:0] att_w      [MAX_SIZE];
  logic [ATT_N-1:0][MAX_SIZE-1:0] prev_att_w [MAX_SIZE];
  logic [COL_W-1:0]               q_w        [MAX_SIZE];
  cell_ctl_t                      ctl_w      [MAX_SIZE];
  logic [MAX_SIZE-1:0]            place_w;

  logic [4:0]           n_full;
  logic [NW-1:0]        n_w;
  logic [RW-1:0]        rm1;
  logic [MAX_SIZE-1:0]  cand_oh;
  logic [MAX_SIZE-1:0]  blk_mask;
  logic                 blocked;
  logic                 last_row;
  logic                 out_free;
  logic                 do_place;
  logic                 fin;
  logic                 fin_found;
  logic [COL_W-1:0]     row_col [PLACE_ROWS];
  logic [PLACE_W-1:0]   placement;

  // Clamp the board size into the supported range
  always_comb begin
    n_full = {1'b0, bs_r};
    if (bs_r == '0) begin
      n_full = 5'd1;
    end else if (n_full > 5'(MAX_SIZE)) begin
      n_full = 5'(MAX_SIZE);
    end
    n_w = NW'(n_full);
  end

  // Safety check against the current row's masks
  assign rm1      = r_r - RW'(1);
  assign cand_oh  = {{(MAX_SIZE-1){1'b0}}, 1'b1} << c_r;
  assign blk_mask = att_w[r_r][ATT_COL] | att_w[r_r][ATT_DL] | att_w[r_r][ATT_DR];
  assign blocked  = |(blk_mask & cand_oh);
  assign last_row = (NW'(r_r) + NW'(1)) == n_w;
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  // Next state: one trial or backtrack step per cycle, held on the final step while the output is busy
  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    exh_nxt   = exh_r;
    cnt_nxt   = cnt_r;
    do_place  = 1'b0;
    fin       = 1'b0;
    fin_found = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_SEARCH;
          if (in_tdata[0]) begin
            r_nxt   = '0;
            c_nxt   = '0;
            exh_nxt = 1'b0;
            cnt_nxt = '0;
          end
        end
      end
      ST_SEARCH: begin
        priority if (exh_r) begin
          if (out_free) begin
            fin       = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (c_r >= n_w) begin
          if (r_r == '0) begin
            if (out_free) begin
              exh_nxt   = 1'b1;
              fin       = 1'b1;
              state_nxt = ST_IDLE;
            end
          end else begin
            r_nxt = rm1;
            c_nxt = NW'(q_w[rm1]) + NW'(1);
          end
        end else if (!blocked) begin
          if (last_row) begin
            if (out_free) begin
              do_place  = 1'b1;
              fin       = 1'b1;
              fin_found = 1'b1;
              c_nxt     = c_r + NW'(1);
              cnt_nxt   = cnt_r + COUNT_W'(1);
              state_nxt = ST_IDLE;
            end
          end else begin
            do_place = 1'b1;
            r_nxt    = r_r + RW'(1);
            c_nxt    = '0;
          end
        end else begin
          c_nxt = c_r + NW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // A size write empties the search
    if (cfg_wr_en) begin
      r_nxt   = '0;
      c_nxt   = '0;
      exh_nxt = 1'b0;
      cnt_nxt = '0;
    end
  end

  assign place_w = do_place ? ({{(MAX_SIZE-1){1'b0}}, 1'b1} << r_r) : '0;

  // Row cells
  for (genvar i = 0; i < MAX_SIZE; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_att_w[i] = '0;
      assign ctl_w[i].take = 1'b0;
    end else begin : g_next
      assign prev_att_w[i] = att_w[i-1];
      assign ctl_w[i].take = place_w[i-1];
    end
    assign ctl_w[i].place = place_w[i];

    nqe_cell #(
      .MAX_SIZE (MAX_SIZE)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl_w[i]),
      .cand_col (COL_W'(c_r)),
      .prev_att (prev_att_w[i]),
      .col      (q_w[i]),
      .att      (att_w[i])
    );
  end

  // Gather the placement, taking the column being placed this cycle
  for (genvar i = 0; i < PLACE_ROWS; i++) begin : g_row
    if (i < MAX_SIZE) begin : g_live
      assign row_col[i] = (NW'(i) >= n_w) ? '0 :
                          (r_r == RW'(i)) ? COL_W'(c_r) : q_w[i];
    end else begin : g_dead
      assign row_col[i] = '0;
    end
    assign placement[i*COL_W +: COL_W] = row_col[i];
  end

  // Search registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bs_r    <= SIZE_RESET;
      r_r     <= '0;
      c_r     <= '0;
      exh_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      exh_r   <= exh_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr_en) begin
        bs_r <= cfg_wr_data;
      end
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_place_r <= fin_found ? placement : '0;
      out_found_r <= fin_found;
      out_cnt_r   <= cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_place_r};
  assign out_tuser  = out_found_r;

  // A spent search reports an empty placement
  a_empty_when_spent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[PLACE_W-1:0] == '0)
    else $error("placement not empty on a spent search");

  // At most one row places a queen per cycle
  a_one_place: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(place_w))
    else $error("more than one row cell placing");

  // An accepted request starts the search
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_SEARCH)
    else $error("request accepted without starting the search");

  // A result is only produced while searching with the output free
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> state_r == ST_SEARCH && out_free)
    else $error("result produced over a held result");

endmodule
